### sv/prtok_pkg.sv
// Shared types and codes for the protobuf record tokenizer.
`default_nettype none

package prtok_pkg;

    localparam int LEN_BITS_DEFAULT = 32;

    localparam int VARINT_BITS = 64;
    localparam int FIELD_BITS = 29;
    localparam logic [3:0] MAX_GROUPS = 4'd10;

    localparam int FIXED64_BYTES = 8;
    localparam int FIXED32_BYTES = 4;

    localparam logic [2:0] PH_KEY     = 3'd0;
    localparam logic [2:0] PH_VARBODY = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    localparam logic [1:0] STAT_COMPLETE  = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN   = 2'd1;
    localparam logic [1:0] STAT_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } src_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] field_number;
        logic [2:0]            wire_type;
        logic [31:0]           payload_length;
        logic [1:0]            status;
    } rec_item_t;

    typedef struct packed {
        logic [2:0]             phase;
        logic [VARINT_BITS-1:0] acc;
        logic [3:0]             groups;
        logic [FIELD_BITS-1:0]  field;
        logic [2:0]             wtype;
    } tok_ctl_t;

endpackage

`default_nettype wire

### sv/protobuf_record_tokenizer_core.sv
// Top level: protobuf wire-format record tokenizer with registered request channels.
`default_nettype none

// Takes one buffer byte per request on src and returns one record request on rec
// whenever a record ends or fails. Throughput is one byte per clock while rec is not
// stalled; the input register takes the byte, and the tokenizer state update then
// writes the byte's record into the result register. The state update loop sets the
// rate. Status 0 is a complete record, 1 an unknown wire type, 2 a body or length
// cut off by the buffer end or a length wider than LEN_BITS.

module protobuf_record_tokenizer_core
    import prtok_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  var logic      clk,
    input  var logic      rst_n,
    input  var logic      src_valid,
    output logic          src_ready,
    input  var src_item_t src_data,
    output logic          rec_valid,
    input  var logic      rec_ready,
    output rec_item_t     rec_data
);

    logic                src_valid_reg;
    src_item_t           src_data_reg;
    tok_ctl_t            ctl_reg;
    tok_ctl_t            ctl_next;
    logic [LEN_BITS-1:0] held_length_reg;
    logic [LEN_BITS-1:0] held_length_next;
    logic [LEN_BITS-1:0] skip_count_reg;
    logic [LEN_BITS-1:0] skip_count_next;
    logic                rec_valid_reg;
    rec_item_t           rec_data_reg;
    rec_item_t           rec_data_next;
    logic                emit;
    logic                proc_fire;

    assign proc_fire = src_valid_reg && (!rec_valid_reg || rec_ready);
    assign src_ready = !src_valid_reg || proc_fire;
    assign rec_valid = rec_valid_reg;
    assign rec_data  = rec_data_reg;

    prtok_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .item             (src_data_reg),
        .ctl              (ctl_reg),
        .held_length      (held_length_reg),
        .skip_count       (skip_count_reg),
        .ctl_next         (ctl_next),
        .held_length_next (held_length_next),
        .skip_count_next  (skip_count_next),
        .emit             (emit),
        .rec              (rec_data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid_reg   <= 1'b0;
            ctl_reg         <= '0;
            held_length_reg <= '0;
            skip_count_reg  <= '0;
            rec_valid_reg   <= 1'b0;
        end
        else
        begin
            if (src_ready)
                src_valid_reg <= src_valid;
            if (proc_fire)
            begin
                ctl_reg         <= ctl_next;
                held_length_reg <= held_length_next;
                skip_count_reg  <= skip_count_next;
            end
            rec_valid_reg <= (proc_fire && emit) || (rec_valid_reg && !rec_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            src_data_reg <= src_data;
        if (proc_fire && emit)
            rec_data_reg <= rec_data_next;
    end

endmodule

`default_nettype wire

### sv/prtok_step.sv
// Per-byte next-state and record-emit logic of the tokenizer.
`default_nettype none

module prtok_step
    import prtok_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  var src_item_t           item,
    input  var tok_ctl_t            ctl,
    input  var logic [LEN_BITS-1:0] held_length,
    input  var logic [LEN_BITS-1:0] skip_count,
    output tok_ctl_t                ctl_next,
    output logic [LEN_BITS-1:0]     held_length_next,
    output logic [LEN_BITS-1:0]     skip_count_next,
    output logic                    emit,
    output rec_item_t               rec
);

    localparam logic [VARINT_BITS-1:0] HIGH_MASK =
        ~((64'd1 << LEN_BITS) - 64'd1);

    logic                   ends;
    logic [6:0]             shamt;
    logic [VARINT_BITS-1:0] grp_shift;
    logic [VARINT_BITS-1:0] acc_g;
    logic [3:0]             groups_g;
    logic [LEN_BITS-1:0]    skip_dec;
    logic                   fits;
    logic [2:0]             key_type;
    logic [2:0]             e_type;
    logic [FIELD_BITS-1:0]  e_field;
    logic [31:0]            e_len;
    logic [1:0]             e_stat;

    assign ends  = !item.byte_value[7] || item.last_byte;
    assign shamt = {ctl.groups, 3'b000} - {3'b000, ctl.groups};
    assign grp_shift = {57'd0, item.byte_value[6:0]} << shamt;

    always_comb
    begin
        if (ctl.groups < MAX_GROUPS)
        begin
            acc_g    = ctl.acc | grp_shift;
            groups_g = ctl.groups + 4'd1;
        end
        else
        begin
            acc_g    = ctl.acc;
            groups_g = ctl.groups;
        end
    end

    assign skip_dec = (skip_count != '0) ? skip_count - LEN_BITS'(1) : skip_count;
    assign fits     = (acc_g & HIGH_MASK) == '0;
    assign key_type = acc_g[2:0];

    always_comb
    begin
        ctl_next         = ctl;
        held_length_next = held_length;
        skip_count_next  = skip_count;
        emit             = 1'b0;
        e_type           = ctl.wtype;
        e_field          = ctl.field;
        e_len            = 32'd0;
        e_stat           = STAT_COMPLETE;

        unique case (ctl.phase)
            PH_KEY:
            begin
                ctl_next.acc    = acc_g;
                ctl_next.groups = groups_g;
                if (ends)
                begin
                    ctl_next.field   = acc_g[FIELD_BITS+2:3];
                    ctl_next.wtype   = key_type;
                    ctl_next.acc     = '0;
                    ctl_next.groups  = 4'd0;
                    held_length_next = '0;
                    e_type           = key_type;
                    e_field          = acc_g[FIELD_BITS+2:3];
                    if (key_type == WT_VARINT || key_type == WT_LEN)
                    begin
                        if (item.last_byte)
                            emit = 1'b1;
                        else
                            ctl_next.phase = (key_type == WT_VARINT) ? PH_VARBODY : PH_LEN;
                    end
                    else if (key_type == WT_FIXED64 || key_type == WT_FIXED32)
                    begin
                        if (item.last_byte)
                        begin
                            emit   = 1'b1;
                            e_stat = STAT_TRUNCATED;
                        end
                        else
                        begin
                            skip_count_next = (key_type == WT_FIXED64) ?
                                LEN_BITS'(FIXED64_BYTES) : LEN_BITS'(FIXED32_BYTES);
                            ctl_next.phase  = PH_SKIP;
                        end
                    end
                    else
                    begin
                        emit           = 1'b1;
                        e_stat         = STAT_UNKNOWN;
                        ctl_next.phase = PH_ERROR;
                    end
                end
            end
            PH_VARBODY:
            begin
                if (ends)
                begin
                    emit           = 1'b1;
                    ctl_next.phase = PH_KEY;
                end
            end
            PH_LEN:
            begin
                ctl_next.acc    = acc_g;
                ctl_next.groups = groups_g;
                if (ends)
                begin
                    held_length_next = LEN_BITS'(acc_g);
                    ctl_next.acc     = '0;
                    ctl_next.groups  = 4'd0;
                    e_len            = acc_g[31:0];
                    if (!fits)
                    begin
                        emit           = 1'b1;
                        e_stat         = STAT_TRUNCATED;
                        ctl_next.phase = PH_ERROR;
                    end
                    else if (acc_g == '0)
                    begin
                        emit           = 1'b1;
                        ctl_next.phase = PH_KEY;
                    end
                    else if (item.last_byte)
                    begin
                        emit   = 1'b1;
                        e_stat = STAT_TRUNCATED;
                    end
                    else
                    begin
                        skip_count_next = LEN_BITS'(acc_g);
                        ctl_next.phase  = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                skip_count_next = skip_dec;
                e_len           = 32'(held_length);
                if (skip_dec == '0)
                begin
                    emit           = 1'b1;
                    ctl_next.phase = PH_KEY;
                end
                else if (item.last_byte)
                begin
                    emit   = 1'b1;
                    e_stat = STAT_TRUNCATED;
                end
            end
            default:
            begin
            end
        endcase

        // end of buffer: next byte opens a new record
        if (item.last_byte)
        begin
            ctl_next.phase  = PH_KEY;
            ctl_next.acc    = '0;
            ctl_next.groups = 4'd0;
            skip_count_next = '0;
        end
    end

    always_comb
    begin
        rec.field_number   = e_field;
        rec.wire_type      = e_type;
        rec.payload_length = (e_type == WT_LEN) ? e_len : 32'd0;
        rec.status         = e_stat;
    end

endmodule

`default_nettype wire

### sv/prtok_checker.sv
// Port-level checks on the tokenizer's record channel, bound to the top level.
`default_nettype none

module prtok_checker
    import prtok_pkg::*;
(
    input var logic      clk,
    input var logic      rst_n,
    input var logic      rec_valid,
    input var logic      rec_ready,
    input var rec_item_t rec_data
);

    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec_data))
        else $error("record request dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> rec_data.status == STAT_COMPLETE || rec_data.status == STAT_UNKNOWN ||
            rec_data.status == STAT_TRUNCATED)
        else $error("record status out of range");

    a_len_only_type2: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.wire_type != WT_LEN |-> rec_data.payload_length == 32'd0)
        else $error("payload length on a record that is not length-delimited");

    a_unknown_type: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.status == STAT_UNKNOWN |->
            rec_data.wire_type != WT_VARINT && rec_data.wire_type != WT_FIXED64 &&
            rec_data.wire_type != WT_LEN && rec_data.wire_type != WT_FIXED32)
        else $error("unknown-type status on a known wire type");

    a_trunc_type: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_data.status == STAT_TRUNCATED |->
            rec_data.wire_type == WT_FIXED64 || rec_data.wire_type == WT_LEN ||
            rec_data.wire_type == WT_FIXED32)
        else $error("truncated status on a wire type without a body");

endmodule

bind protobuf_record_tokenizer_core prtok_checker u_prtok_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_data  (rec_data)
);

`default_nettype wire

### tb/sv/protobuf_record_tokenizer_core_test.sv
// Self-checking testbench for the protobuf record tokenizer: directed table, random buffers.
module protobuf_record_tokenizer_core_test;
    import prtok_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_BITS = LEN_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTES_PER_PHASE = 437;
    localparam int IDLE_PCT [4] = '{0, 49, 0, 17};
    localparam int STALL_PCT [4] = '{0, 0, 49, 17};

    typedef enum logic [1:0] {FROM_MODEL, NO_RECORD, FIXED_RECORD} rec_src_t;

    typedef struct packed {
        src_item_t item;
        rec_src_t  kind;
        rec_item_t want;
    } dir_row_t;

    localparam rec_item_t NONE_REC = '0;

    localparam dir_row_t DIRECTED_ROWS [25] = '{
        '{'{8'h08, 1'b0}, FROM_MODEL, NONE_REC},
        '{'{8'h96, 1'b0}, FROM_MODEL, NONE_REC},
        '{'{8'h01, 1'b0}, FROM_MODEL, NONE_REC},
        '{'{8'h12, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h00, 1'b0}, FIXED_RECORD, '{29'd2, WT_LEN, 32'd0, STAT_COMPLETE}},
        '{'{8'h0B, 1'b0}, FIXED_RECORD, '{29'd1, 3'd3, 32'd0, STAT_UNKNOWN}},
        '{'{8'hFF, 1'b1}, NO_RECORD, NONE_REC},
        '{'{8'h88, 1'b1}, FIXED_RECORD, '{29'd1, WT_VARINT, 32'd0, STAT_COMPLETE}},
        '{'{8'h0D, 1'b1}, FIXED_RECORD, '{29'd1, WT_FIXED32, 32'd0, STAT_TRUNCATED}},
        '{'{8'hFF, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'hFF, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'hFF, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'hFF, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h0F, 1'b1}, FIXED_RECORD, '{29'h1fffffff, 3'd7, 32'd0, STAT_UNKNOWN}},
        '{'{8'h1A, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h80, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h80, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h80, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h80, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h10, 1'b0}, FIXED_RECORD, '{29'd3, WT_LEN, 32'd0, STAT_TRUNCATED}},
        '{'{8'h55, 1'b1}, NO_RECORD, NONE_REC},
        '{'{8'h22, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'h03, 1'b0}, NO_RECORD, NONE_REC},
        '{'{8'hAA, 1'b0}, FROM_MODEL, NONE_REC},
        '{'{8'hBB, 1'b1}, FIXED_RECORD, '{29'd4, WT_LEN, 32'd3, STAT_TRUNCATED}}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    src_item_t src_data = '0;
    logic      rec_valid;
    logic      rec_ready = 1'b0;
    rec_item_t rec_data;

    rec_src_t  row_kind = FROM_MODEL;
    rec_item_t row_want = '0;

    int src_idle_pct = 0;
    int rec_stall_pct = 0;
    int cycles = 0;
    int mismatches = 0;
    int bytes_parsed = 0;

    rec_item_t  records_due [$];
    logic [7:0] buffer_bytes [$];

    // predictor state
    logic [2:0]            tok_phase = PH_KEY;
    logic [63:0]           tok_acc = '0;
    logic [3:0]            tok_groups = '0;
    logic [FIELD_BITS-1:0] tok_field = '0;
    logic [2:0]            tok_type = '0;
    logic [63:0]           tok_len = '0;
    logic [63:0]           tok_skip = '0;

    rec_item_t  pred_rec;
    rec_item_t  head_rec;

    protobuf_record_tokenizer_core #(
        .LEN_BITS(LEN_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_data(src_data),
        .rec_valid(rec_valid),
        .rec_ready(rec_ready),
        .rec_data(rec_data)
    );

    always #2 clk = ~clk;

    function automatic void add_byte(input logic [7:0] b);
        buffer_bytes = {buffer_bytes, b};
    endfunction

    function automatic void add_due(input rec_item_t r);
        records_due = {records_due, r};
    endfunction

    function automatic void take_group(input logic [7:0] b);
        if (tok_groups < MAX_GROUPS)
        begin
            tok_acc = tok_acc | (64'(b[6:0]) << (7 * tok_groups));
            tok_groups = tok_groups + 4'd1;
        end
    endfunction

    // One byte through the tokenizer; returns 1 when a record ends or fails.
    function automatic bit tokenize_byte(input src_item_t it, output rec_item_t rec);
        logic [7:0]  b;
        logic        last;
        logic        ends;
        bit          hit;
        logic [2:0]  nxt;
        logic [1:0]  st;
        logic [63:0] plen;
        b = it.byte_value;
        last = it.last_byte;
        ends = !b[7] || last;
        hit = 1'b0;
        nxt = tok_phase;
        st = STAT_COMPLETE;
        plen = '0;
        rec = '0;
        case (tok_phase)
            PH_KEY:
            begin
                take_group(b);
                if (ends)
                begin
                    tok_field = tok_acc[FIELD_BITS+2:3];
                    tok_type = tok_acc[2:0];
                    tok_len = '0;
                    tok_acc = '0;
                    tok_groups = '0;
                    if (tok_type == WT_VARINT || tok_type == WT_LEN)
                    begin
                        if (last)
                            hit = 1'b1;
                        else
                            nxt = (tok_type == WT_VARINT) ? PH_VARBODY : PH_LEN;
                    end
                    else if (tok_type == WT_FIXED64 || tok_type == WT_FIXED32)
                    begin
                        if (last)
                        begin
                            hit = 1'b1;
                            st = STAT_TRUNCATED;
                        end
                        else
                        begin
                            tok_skip = (tok_type == WT_FIXED64) ? 64'(FIXED64_BYTES)
                                                                : 64'(FIXED32_BYTES);
                            nxt = PH_SKIP;
                        end
                    end
                    else
                    begin
                        hit = 1'b1;
                        st = STAT_UNKNOWN;
                        nxt = PH_ERROR;
                    end
                end
            end
            PH_VARBODY:
            begin
                if (ends)
                begin
                    hit = 1'b1;
                    nxt = PH_KEY;
                end
            end
            PH_LEN:
            begin
                take_group(b);
                if (ends)
                begin
                    tok_len = tok_acc;
                    tok_acc = '0;
                    tok_groups = '0;
                    if ((tok_len >> LEN_BITS) != 0)
                    begin
                        hit = 1'b1;
                        st = STAT_TRUNCATED;
                        plen = tok_len;
                        nxt = PH_ERROR;
                    end
                    else if (tok_len == 0)
                    begin
                        hit = 1'b1;
                        nxt = PH_KEY;
                    end
                    else if (last)
                    begin
                        hit = 1'b1;
                        st = STAT_TRUNCATED;
                        plen = tok_len;
                    end
                    else
                    begin
                        tok_skip = tok_len;
                        nxt = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (tok_skip != 0)
                    tok_skip = tok_skip - 1;
                if (tok_skip == 0)
                begin
                    hit = 1'b1;
                    plen = tok_len;
                    nxt = PH_KEY;
                end
                else if (last)
                begin
                    hit = 1'b1;
                    st = STAT_TRUNCATED;
                    plen = tok_len;
                end
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            nxt = PH_KEY;
            tok_acc = '0;
            tok_groups = '0;
            tok_skip = '0;
        end
        tok_phase = nxt;
        if (hit)
        begin
            rec.field_number = tok_field;
            rec.wire_type = tok_type;
            rec.payload_length = (tok_type == WT_LEN) ? plen[31:0] : 32'd0;
            rec.status = st;
        end
        return hit;
    endfunction

    task automatic flag_record(input string what, input rec_item_t want, input rec_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: exp fn=%h wt=%0d len=%h st=%0d got fn=%h wt=%0d len=%h st=%0d",
                     $realtime, what, want.field_number, want.wire_type, want.payload_length,
                     want.status, got.field_number, got.wire_type, got.payload_length,
                     got.status);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL protobuf_record_tokenizer_core");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rec_ready <= 1'b0;
        else
            rec_ready <= ($urandom_range(99) >= rec_stall_pct);
    end

    // accepted requests on both channels
    always @(posedge clk)
    begin
        if (rst_n && src_valid && src_ready)
        begin
            bytes_parsed++;
            if (tokenize_byte(src_data, pred_rec) && row_kind == FROM_MODEL)
                add_due(pred_rec);
            if (row_kind == FIXED_RECORD)
                add_due(row_want);
        end
        if (rst_n && rec_valid && rec_ready)
        begin
            if (records_due.size() == 0)
                flag_record("unexpected record", NONE_REC, rec_data);
            else
            begin
                head_rec = records_due.pop_front();
                if (rec_data.field_number !== head_rec.field_number
                    || rec_data.wire_type !== head_rec.wire_type
                    || rec_data.payload_length !== head_rec.payload_length
                    || rec_data.status !== head_rec.status)
                    flag_record("record mismatch", head_rec, rec_data);
            end
        end
    end

    task automatic send_byte(input src_item_t it, input rec_src_t kind, input rec_item_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data <= it;
        row_kind <= kind;
        row_want <= want;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
    endtask

    // pad adds redundant groups; groups past the tenth carry random ignored bits
    task automatic put_varint(input logic [63:0] v, input int pad);
        logic [63:0] r;
        int          g;
        int          k;
        r = v;
        g = 0;
        while (r >= 64'h80)
        begin
            add_byte({1'b1, r[6:0]});
            r = r >> 7;
            g++;
        end
        if (pad == 0)
            add_byte({1'b0, r[6:0]});
        else
        begin
            add_byte({1'b1, r[6:0]});
            g++;
            for (k = 1; k < pad; k++)
            begin
                add_byte((g >= 10) ? {1'b1, 7'($urandom)} : 8'h80);
                g++;
            end
            add_byte((g >= 10) ? {1'b0, 7'($urandom)} : 8'h00);
        end
    endtask

    function automatic int pick_pad();
        int r;
        r = $urandom_range(99);
        if (r < 86)
            return 0;
        else if (r < 96)
            return $urandom_range(1, 3);
        else
            return $urandom_range(9, 12);
    endfunction

    task automatic put_record();
        logic [28:0] fld;
        logic [2:0]  wt;
        logic [63:0] key;
        logic [63:0] len;
        int          r;
        int          k;
        r = $urandom_range(99);
        if (r < 70)
            fld = 29'($urandom_range(1, 31));
        else if (r < 88)
            fld = 29'($urandom);
        else if (r < 96)
            fld = 29'h1fffffff;
        else
            fld = '0;
        r = $urandom_range(99);
        if (r < 28)
            wt = WT_VARINT;
        else if (r < 43)
            wt = WT_FIXED64;
        else if (r < 75)
            wt = WT_LEN;
        else if (r < 91)
            wt = WT_FIXED32;
        else
        begin
            wt = 3'($urandom_range(3, 7));
            if (wt == WT_FIXED32)
                wt = 3'd3;
        end
        key = {32'd0, fld, wt};
        if ($urandom_range(99) < 5)
            key[63:32] = $urandom;
        put_varint(key, pick_pad());
        case (wt)
            WT_VARINT:
                put_varint({$urandom, $urandom} >> $urandom_range(0, 63), pick_pad());
            WT_FIXED64, WT_FIXED32:
                for (k = 0; k < ((wt == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES); k++)
                    add_byte(8'($urandom));
            WT_LEN:
            begin
                r = $urandom_range(99);
                if (r < 6)
                begin
                    len = {$urandom, $urandom};
                    if (LEN_BITS < 64)
                        len = len | (64'd1 << LEN_BITS);
                    put_varint(len, pick_pad());
                    repeat ($urandom_range(0, 3))
                        add_byte(8'($urandom));
                end
                else
                begin
                    len = (r < 90) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(13, 40));
                    put_varint(len, pick_pad());
                    for (k = 0; k < int'(len); k++)
                        add_byte(8'($urandom));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_buffer();
        int n;
        int k;
        src_item_t it;
        buffer_bytes.delete();
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(1, 8))
                add_byte(8'($urandom));
        else
            repeat ($urandom_range(1, 4))
                put_record();
        n = buffer_bytes.size();
        if ($urandom_range(99) < 25)
            n = $urandom_range(1, n);
        for (k = 0; k < n; k++)
        begin
            it.byte_value = buffer_bytes[k];
            it.last_byte = (k == n - 1);
            send_byte(it, FROM_MODEL, NONE_REC);
        end
    endtask

    initial
    begin
        int ph;
        int k;
        int goal;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (k = 0; k < 25; k++)
            send_byte(DIRECTED_ROWS[k].item, DIRECTED_ROWS[k].kind, DIRECTED_ROWS[k].want);
        for (ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = IDLE_PCT[ph];
            rec_stall_pct = STALL_PCT[ph];
            goal = bytes_parsed + BYTES_PER_PHASE;
            while (bytes_parsed < goal)
                send_buffer();
        end
        src_valid <= 1'b0;
        @(posedge clk);
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        mismatches += records_due.size();
        if (mismatches == 0)
            $display("PASS protobuf_record_tokenizer_core");
        else
            $display("FAIL protobuf_record_tokenizer_core");
        $finish;
    end

endmodule
